@@ rtl/svpwm_pkg.sv @@
// Shared constants for the SVPWM min-max duty generator.
package svpwm_pkg;

   // default field widths
   localparam int VOLT_WIDTH_DEFAULT     = 16;
   localparam int DUTY_FRAC_BITS_DEFAULT = 15;

   // modulation limit full scale (1.0 in Q1.15) and its reset value
   localparam int LIMIT_ONE = 32768;

   // round(2^16 / sqrt(3)) and round(2^16 * sqrt(3) / 2)
   localparam int INV_SQRT3_Q16  = 37837;
   localparam int HALF_SQRT3_Q16 = 56756;

   // register indexes on the CSR port
   typedef enum logic {
      REG_VEC_LIMIT = 1'b0,
      REG_UNUSED    = 1'b1
   } csr_reg_type;

endpackage

@@ rtl/svpwm_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module svpwm_isqrt #(
   parameter int RW = 24,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_radicand,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);

   logic            val_ff  [RW];
   logic [2*RW-1:0] x_ff    [RW];
   logic [RW+1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [SW-1:0]   side_ff [RW];

   genvar i;
   for (i = 0; i < RW; i++) begin : g_step
      logic            val_cur;
      logic [2*RW-1:0] x_cur;
      logic [RW+1:0]   rem_cur;
      logic [RW-1:0]   root_cur;
      logic [SW-1:0]   side_cur;
      logic [RW+1:0]   rem_sh;
      logic [RW+1:0]   trial;
      logic            ge;

      if (i == 0) begin : g_first
         assign val_cur  = in_valid;
         assign x_cur    = in_radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign val_cur  = val_ff[i-1];
         assign x_cur    = x_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // bring in the next two radicand bits and try the next root bit
      assign rem_sh = {rem_cur[RW-1:0], x_cur[2*RW-1 -: 2]};
      assign trial  = {root_cur, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i] <= 1'b0;
         end else if (en) begin
            val_ff[i] <= val_cur;
         end
         if (en) begin
            x_ff[i]    <= x_cur << 2;
            rem_ff[i]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[i] <= {root_cur[RW-2:0], ge};
            side_ff[i] <= side_cur;
         end
      end
   end

   assign out_valid = val_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

@@ rtl/svpwm_div.sv @@
// Pipelined restoring divider, several lanes over one shared divisor.
module svpwm_div #(
   parameter int DW    = 24,
   parameter int QW    = 24,
   parameter int LANES = 2,
   parameter int SW    = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [DW-1:0]             in_den,
   // high part of each numerator, must be below the divisor
   input  logic [LANES-1:0][DW-1:0]  in_rem,
   input  logic [LANES-1:0][QW-1:0]  in_low,
   input  logic [SW-1:0]             in_side,
   output logic                      out_valid,
   output logic [LANES-1:0][QW-1:0]  out_quo,
   output logic [SW-1:0]             out_side
);

   logic                     val_ff  [QW];
   logic [DW-1:0]            den_ff  [QW];
   logic [LANES-1:0][DW-1:0] rem_ff  [QW];
   logic [LANES-1:0][QW-1:0] low_ff  [QW];
   logic [SW-1:0]            side_ff [QW];

   genvar i;
   for (i = 0; i < QW; i++) begin : g_step
      logic                     val_cur;
      logic [DW-1:0]            den_cur;
      logic [LANES-1:0][DW-1:0] rem_cur;
      logic [LANES-1:0][QW-1:0] low_cur;
      logic [SW-1:0]            side_cur;
      logic [LANES-1:0][DW-1:0] rem_nx;
      logic [LANES-1:0][QW-1:0] low_nx;

      if (i == 0) begin : g_first
         assign val_cur  = in_valid;
         assign den_cur  = in_den;
         assign rem_cur  = in_rem;
         assign low_cur  = in_low;
         assign side_cur = in_side;
      end else begin : g_next
         assign val_cur  = val_ff[i-1];
         assign den_cur  = den_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign low_cur  = low_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // shift one numerator bit in, subtract when it fits, shift quotient bit in
      always_comb begin
         logic [DW:0] t;
         logic        ge;
         for (int k = 0; k < LANES; k++) begin
            t         = {rem_cur[k], low_cur[k][QW-1]};
            ge        = (t >= {1'b0, den_cur});
            rem_nx[k] = ge ? DW'(t - {1'b0, den_cur}) : DW'(t);
            low_nx[k] = {low_cur[k][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i] <= 1'b0;
         end else if (en) begin
            val_ff[i] <= val_cur;
         end
         if (en) begin
            den_ff[i]  <= den_cur;
            rem_ff[i]  <= rem_nx;
            low_ff[i]  <= low_nx;
            side_ff[i] <= side_cur;
         end
      end
   end

   assign out_valid = val_ff[QW-1];
   assign out_quo   = low_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

@@ rtl/svpwm_minmax_duty_generator.sv @@
// Top level of the SVPWM min-max duty generator: stream in, duties out, CSR port.
//
// Takes one alpha/beta/bus command per cycle and returns three Q(DUTY_FRAC_BITS)
// phase duties plus a limit flag. The datapath is a single stall-as-a-whole
// pipeline: two input stages, a one-bit-per-stage square root (VOLT_WIDTH+8
// stages), a limit-compare stage, the vector scaling divider (VOLT_WIDTH+8
// stages), five arithmetic stages, the duty divider (DUTY_FRAC_BITS+1 stages)
// and the output register.
// Throughput is one item per cycle while rsp_tready stays high. Commands with a
// zero bus voltage are dropped and give no result. The vector length limit
// register sits at byte address 0; the user must write it only while the pipeline
// is empty, and the block itself does not enforce this.
module svpwm_minmax_duty_generator #(
   parameter int VOLT_WIDTH     = svpwm_pkg::VOLT_WIDTH_DEFAULT,
   parameter int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // alpha_voltage, beta_voltage, bus_millivolts, zero pad
   input  logic [((3*VOLT_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // phase_a_duty, phase_b_duty, phase_c_duty, was_limited, zero pad
   output logic [55:0]                           rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [2:0]                            csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int W    = VOLT_WIDTH;
   localparam int F    = DUTY_FRAC_BITS;
   localparam int MW   = W + 8;
   localparam int PV   = W + 10;
   localparam int P4W  = W + 12;
   localparam int PMW  = W + 11;
   localparam int DDW  = W + 10;
   localparam int DQW  = F + 1;
   localparam int NUMW = W + 12 + F;
   localparam int SW1  = 3 * W + 2 + MW;
   localparam int SW2  = W + 3;
   localparam int SW3  = 7;

   // ---------------- configuration register
   logic [15:0] lim_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= 16'(svpwm_pkg::LIMIT_ONE);
      end else if (csr_wr && (csr_paddr[2] == svpwm_pkg::REG_VEC_LIMIT)) begin
         lim_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == svpwm_pkg::REG_VEC_LIMIT) ?
                       {16'b0, lim_ff} : 32'b0;

   // ---------------- pipeline advance
   logic pipe_en;
   logic rsp_valid_ff;

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;

   // ---------------- stage 1: unpack, magnitudes, squares, bus times limit
   logic [W-1:0]  a_raw, b_raw, bus_raw, a_abs, b_abs;
   logic [15:0]   lim_eff;

   assign a_raw   = req_tdata[W-1:0];
   assign b_raw   = req_tdata[2*W-1:W];
   assign bus_raw = req_tdata[3*W-1:2*W];
   assign a_abs   = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
   assign b_abs   = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
   assign lim_eff = (lim_ff > 16'(svpwm_pkg::LIMIT_ONE)) ?
                    16'(svpwm_pkg::LIMIT_ONE) : lim_ff;

   logic          v1_ff;
   logic [W-1:0]  a1_ff, b1_ff, bus1_ff;
   logic          sa1_ff, sb1_ff;
   logic [2*W-1:0] aa1_ff, bb1_ff;
   logic [W+15:0] bl1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_tvalid && (bus_raw != '0);
      end
      if (pipe_en) begin
         a1_ff   <= a_abs;
         b1_ff   <= b_abs;
         sa1_ff  <= a_raw[W-1];
         sb1_ff  <= b_raw[W-1];
         bus1_ff <= bus_raw;
         aa1_ff  <= a_abs * a_abs;
         bb1_ff  <= b_abs * b_abs;
         bl1_ff  <= bus_raw * lim_eff;
      end
   end

   // ---------------- stage 2: sum of squares, limit in Q.8
   logic          v2_ff;
   logic [W-1:0]  a2_ff, b2_ff, bus2_ff;
   logic          sa2_ff, sb2_ff;
   logic [2*W-1:0] sq2_ff;
   logic [W+31:0] mx2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (pipe_en) begin
         v2_ff <= v1_ff;
      end
      if (pipe_en) begin
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         sa2_ff  <= sa1_ff;
         sb2_ff  <= sb1_ff;
         bus2_ff <= bus1_ff;
         sq2_ff  <= aa1_ff + bb1_ff;
         mx2_ff  <= bl1_ff * 16'(svpwm_pkg::INV_SQRT3_Q16);
      end
   end

   // ---------------- magnitude: sqrt of (a^2 + b^2) * 2^16
   logic           sq_valid;
   logic [MW-1:0]  sq_root;
   logic [SW1-1:0] sq_side;

   svpwm_isqrt #(
      .RW (MW),
      .SW (SW1)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (v2_ff),
      .in_radicand ({sq2_ff, 16'b0}),
      .in_side     ({a2_ff, b2_ff, sa2_ff, sb2_ff, bus2_ff, mx2_ff[23 +: MW]}),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   logic [W-1:0]  a3, b3, bus3;
   logic          sa3, sb3;
   logic [MW-1:0] max3;

   assign {a3, b3, sa3, sb3, bus3, max3} = sq_side;

   // ---------------- stage 4: limit compare, axis times limit
   logic            v4_ff, lim4_ff, sa4_ff, sb4_ff;
   logic [W-1:0]    a4_ff, b4_ff, bus4_ff;
   logic [MW-1:0]   root4_ff;
   logic [W+MW-1:0] pa4_ff, pb4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (pipe_en) begin
         v4_ff <= sq_valid;
      end
      if (pipe_en) begin
         lim4_ff  <= (sq_root > max3);
         root4_ff <= sq_root;
         a4_ff    <= a3;
         b4_ff    <= b3;
         sa4_ff   <= sa3;
         sb4_ff   <= sb3;
         bus4_ff  <= bus3;
         pa4_ff   <= a3 * max3;
         pb4_ff   <= b3 * max3;
      end
   end

   // ---------------- vector scaling divider; unlimited items divide by one
   logic [MW-1:0]         den1;
   logic [2*MW-1:0]       num1_a, num1_b;
   logic                  d1_valid;
   logic [1:0][MW-1:0]    d1_quo;
   logic [SW2-1:0]        d1_side;

   assign den1   = lim4_ff ? root4_ff : MW'(1);
   assign num1_a = lim4_ff ? {pa4_ff, 8'b0} : (2*MW)'({a4_ff, 8'b0});
   assign num1_b = lim4_ff ? {pb4_ff, 8'b0} : (2*MW)'({b4_ff, 8'b0});

   svpwm_div #(
      .DW    (MW),
      .QW    (MW),
      .LANES (2),
      .SW    (SW2)
   ) u_div_axis (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v4_ff),
      .in_den    (den1),
      .in_rem    ({num1_b[2*MW-1:MW], num1_a[2*MW-1:MW]}),
      .in_low    ({num1_b[MW-1:0], num1_a[MW-1:0]}),
      .in_side   ({sa4_ff, sb4_ff, bus4_ff, lim4_ff}),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   logic         sa_d1, sb_d1, lim_d1;
   logic [W-1:0] bus_d1;

   assign {sa_d1, sb_d1, bus_d1, lim_d1} = d1_side;

   // ---------------- stage 5: beta times sqrt(3)/2
   logic           v5_ff, sa5_ff, sb5_ff, lim5_ff;
   logic [W-1:0]   bus5_ff;
   logic [MW-1:0]  qa5_ff;
   logic [MW+15:0] tp5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (pipe_en) begin
         v5_ff <= d1_valid;
      end
      if (pipe_en) begin
         sa5_ff  <= sa_d1;
         sb5_ff  <= sb_d1;
         lim5_ff <= lim_d1;
         bus5_ff <= bus_d1;
         qa5_ff  <= d1_quo[0];
         tp5_ff  <= d1_quo[1] * 16'(svpwm_pkg::HALF_SQRT3_Q16);
      end
   end

   // ---------------- stage 6: round t, doubled phase voltages
   logic [MW+16:0]        tsum;
   logic [PV-1:0]         tmag;
   logic signed [PV-1:0]  a_pos, a8, t8;

   assign tsum  = (MW+17)'(tp5_ff) + (MW+17)'(16384);
   assign tmag  = tsum[15 +: PV];
   assign a_pos = $signed({2'b00, qa5_ff});
   assign a8    = sa5_ff ? -a_pos : a_pos;
   assign t8    = sb5_ff ? -$signed(tmag) : $signed(tmag);

   logic                 v6_ff, lim6_ff;
   logic [W-1:0]         bus6_ff;
   logic signed [PV-1:0] pa6_ff, pb6_ff, pc6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (pipe_en) begin
         v6_ff <= v5_ff;
      end
      if (pipe_en) begin
         lim6_ff <= lim5_ff;
         bus6_ff <= bus5_ff;
         pa6_ff  <= a8 <<< 1;
         pb6_ff  <= t8 - a8;
         pc6_ff  <= -a8 - t8;
      end
   end

   // ---------------- stage 7: max and min of the phases
   logic signed [PV-1:0] hi_c, lo_c;

   always_comb begin
      hi_c = pa6_ff;
      lo_c = pa6_ff;
      if (pb6_ff > hi_c) hi_c = pb6_ff;
      if (pc6_ff > hi_c) hi_c = pc6_ff;
      if (pb6_ff < lo_c) lo_c = pb6_ff;
      if (pc6_ff < lo_c) lo_c = pc6_ff;
   end

   logic                 v7_ff, lim7_ff;
   logic [W-1:0]         bus7_ff;
   logic signed [PV-1:0] pa7_ff, pb7_ff, pc7_ff, hi7_ff, lo7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (pipe_en) begin
         v7_ff <= v6_ff;
      end
      if (pipe_en) begin
         lim7_ff <= lim6_ff;
         bus7_ff <= bus6_ff;
         pa7_ff  <= pa6_ff;
         pb7_ff  <= pb6_ff;
         pc7_ff  <= pc6_ff;
         hi7_ff  <= hi_c;
         lo7_ff  <= lo_c;
      end
   end

   // ---------------- stage 8: zero-sequence injection
   logic signed [P4W-1:0] hl;

   assign hl = P4W'(hi7_ff) + P4W'(lo7_ff);

   logic                         v8_ff, lim8_ff;
   logic [W-1:0]                 bus8_ff;
   logic signed [2:0][P4W-1:0]   p48_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (pipe_en) begin
         v8_ff <= v7_ff;
      end
      if (pipe_en) begin
         lim8_ff   <= lim7_ff;
         bus8_ff   <= bus7_ff;
         p48_ff[0] <= (P4W'(pa7_ff) <<< 1) - hl;
         p48_ff[1] <= (P4W'(pb7_ff) <<< 1) - hl;
         p48_ff[2] <= (P4W'(pc7_ff) <<< 1) - hl;
      end
   end

   // ---------------- stage 9: duty numerators and saturation check
   logic [2:0][NUMW-1:0] num_c;
   logic [2:0]           sat_c, neg_c;

   always_comb begin
      logic [P4W-1:0] mag;
      for (int k = 0; k < 3; k++) begin
         neg_c[k] = p48_ff[k][P4W-1];
         mag      = neg_c[k] ? (~p48_ff[k] + 1'b1) : p48_ff[k];
         num_c[k] = NUMW'({mag[PMW-1:0], {F{1'b0}}}) + NUMW'({bus8_ff, 9'b0});
         sat_c[k] = (num_c[k][NUMW-1:DQW] >= (NUMW-DQW)'({bus8_ff, 10'b0}));
      end
   end

   logic                 v9_ff, lim9_ff;
   logic [W-1:0]         bus9_ff;
   logic [2:0][NUMW-1:0] num9_ff;
   logic [2:0]           sat9_ff, neg9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (pipe_en) begin
         v9_ff <= v8_ff;
      end
      if (pipe_en) begin
         lim9_ff <= lim8_ff;
         bus9_ff <= bus8_ff;
         num9_ff <= num_c;
         sat9_ff <= sat_c;
         neg9_ff <= neg_c;
      end
   end

   // ---------------- duty divider by 1024 * bus; saturated lanes divide zero
   logic [2:0][DDW-1:0] rem2;
   logic [2:0][DQW-1:0] low2;
   logic                d2_valid;
   logic [2:0][DQW-1:0] d2_quo;
   logic [SW3-1:0]      d2_side;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rem2[k] = sat9_ff[k] ? '0 : num9_ff[k][DDW+DQW-1:DQW];
         low2[k] = sat9_ff[k] ? '0 : num9_ff[k][DQW-1:0];
      end
   end

   svpwm_div #(
      .DW    (DDW),
      .QW    (DQW),
      .LANES (3),
      .SW    (SW3)
   ) u_div_duty (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v9_ff),
      .in_den    ({bus9_ff, 10'b0}),
      .in_rem    (rem2),
      .in_low    (low2),
      .in_side   ({neg9_ff, sat9_ff, lim9_ff}),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   logic [2:0] neg_d2, sat_d2;
   logic       lim_d2;

   assign {neg_d2, sat_d2, lim_d2} = d2_side;

   // ---------------- output register: offset by one half and clamp
   logic [2:0][15:0] duty_c;

   always_comb begin
      logic [DQW-1:0] half, full, d;
      logic           big;
      half = DQW'(1) << (F - 1);
      full = DQW'(1) << F;
      for (int k = 0; k < 3; k++) begin
         big = sat_d2[k] || (d2_quo[k] >= half);
         if (neg_d2[k]) begin
            d = big ? '0 : (half - d2_quo[k]);
         end else begin
            d = big ? full : (half + d2_quo[k]);
         end
         duty_c[k] = 16'(d);
      end
   end

   logic [2:0][15:0] duty_ff;
   logic             lim_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= d2_valid;
      end
      if (pipe_en) begin
         duty_ff    <= duty_c;
         lim_out_ff <= lim_d2;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, lim_out_ff, duty_ff[2], duty_ff[1], duty_ff[0]};

   // ---------------- assertions
   a_zero_bus_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (bus_raw == '0)) |=> !v1_ff)
      else $error("zero-bus item entered the pipeline");

   a_stall_holds_front: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> (v1_ff == $past(v1_ff)) && (v4_ff == $past(v4_ff)))
      else $error("pipeline moved during a stall");

   a_limit_nonzero_mag: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && lim4_ff) |-> (root4_ff != '0))
      else $error("limited vector with zero magnitude");

   a_duty_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (F > 15) ||
         ((rsp_tdata[15:0] <= 16'(1 << F)) && (rsp_tdata[31:16] <= 16'(1 << F)) &&
          (rsp_tdata[47:32] <= 16'(1 << F))))
      else $error("duty above full scale");

endmodule
